### sv/spt_pkg.sv
package spt_pkg;

  localparam int MAX_NODES  = 64;
  localparam int DIST_WIDTH = 32;

  // fixed field widths of the ports
  localparam int IN_DIST_W = 32;
  localparam int VTX_W     = 6;
  localparam int NCNT_W    = 7;

  localparam int NODE_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DADR_W = 2 * NODE_W;
  localparam int CMP_W  = (DIST_WIDTH > IN_DIST_W) ? DIST_WIDTH : IN_DIST_W;

  localparam logic [DIST_WIDTH-1:0] INFINITE = {DIST_WIDTH{1'b1}};

  // register indexes
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_PASS,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] cost;
    logic [NODE_W-1:0]     parent;
    logic                  in_tree;
  } vtx_entry_t;

  typedef struct packed {
    logic              valid;
    logic              init;
    logic              clear;
    logic [NODE_W-1:0] j;
    logic [NODE_W-1:0] k;
  } relax_req_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] k;
    logic [NODE_W-1:0] parent;
  } relax_res_t;

  function automatic logic [DIST_WIDTH-1:0] sat_dist(input logic [IN_DIST_W-1:0] d);
    logic [CMP_W-1:0] dx;
    dx = CMP_W'(d);
    if (dx > CMP_W'(INFINITE)) begin
      return INFINITE;
    end
    return DIST_WIDTH'(dx);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [NCNT_W-1:0] nc);
    if (nc == '0) begin
      return CNT_W'(1);
    end
    if (nc > NCNT_W'(MAX_NODES)) begin
      return CNT_W'(MAX_NODES);
    end
    return CNT_W'(nc);
  endfunction

endpackage

### sv/spt_ram.sv
module spt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/spt_relax.sv
module spt_relax
  import spt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  relax_req_t            req_i,
  input  logic [DIST_WIDTH-1:0] dist_i,
  input  vtx_entry_t            entry_i,
  output logic                  we_o,
  output vtx_entry_t            wdata_o,
  output relax_res_t            res_o
);

  logic                  better;
  logic                  in_tree;
  logic                  cand;
  vtx_entry_t            upd;
  logic                  found_q, found_d;
  logic [DIST_WIDTH-1:0] minc_q, minc_d;
  logic [NODE_W-1:0]     mink_q, mink_d;
  logic [NODE_W-1:0]     minp_q, minp_d;

  // flags left over from the previous run are ignored on the first pass
  assign in_tree = !req_i.init && entry_i.in_tree;

  // the first pass has no previous cost, the edge from the root always wins
  assign better = req_i.init || (dist_i < entry_i.cost);

  always_comb begin
    upd         = entry_i;
    upd.in_tree = 1'b0;
    if (better) begin
      upd.cost   = dist_i;
      upd.parent = req_i.k;
    end
  end

  assign we_o    = req_i.valid && !in_tree && better;
  assign wdata_o = upd;

  // strict compare in ascending order keeps the lowest index on ties
  assign cand = req_i.valid && !in_tree && (!found_q || (upd.cost < minc_q));

  always_comb begin
    found_d = found_q;
    minc_d  = minc_q;
    mink_d  = mink_q;
    minp_d  = minp_q;
    if (req_i.clear) begin
      found_d = 1'b0;
    end else if (cand) begin
      found_d = 1'b1;
      minc_d  = upd.cost;
      mink_d  = req_i.j;
      minp_d  = upd.parent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    minc_q <= minc_d;
    mink_q <= mink_d;
    minp_q <= minp_d;
  end

  assign res_o.found  = found_q;
  assign res_o.k      = mink_q;
  assign res_o.parent = minp_q;

endmodule

### sv/spt_ctrl.sv
module spt_ctrl
  import spt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [NCNT_W-1:0] node_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VTX_W-1:0]  vertex_o,
  output logic [VTX_W-1:0]  parent_o,
  output logic              last_o,
  output logic [NODE_W-1:0] rd_j_o,
  output logic [NODE_W-1:0] rd_k_o,
  output logic              mark_we_o,
  output logic [NODE_W-1:0] mark_addr_o,
  output relax_req_t        req_o,
  input  relax_res_t        res_i
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     n_q, cnt_q;
  logic [NODE_W-1:0]    j_q, k_q;
  logic                 init_q, root_q;
  logic                 s1_v_q;
  logic [NODE_W-1:0]    s1_j_q;
  logic                 out_valid_q;
  logic [VTX_W-1:0]     vertex_q, parent_q;
  logic                 last_q;

  logic                 start;
  logic                 slot_free;
  logic                 emit_fire;
  logic                 emit_last;
  logic                 pass_end;
  logic                 issue;
  logic [NODE_W-1:0]    emit_k;
  logic [NODE_W-1:0]    emit_p;

  assign start     = in_valid_i && in_ready_o && (operation_i == OP_START);
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_k    = root_q ? '0 : res_i.k;
  assign emit_p    = root_q ? '0 : res_i.parent;
  assign emit_last = (cnt_q == n_q - CNT_W'(1));
  assign pass_end  = (CNT_W'(j_q) == n_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = emit_last ? ST_IDLE : ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_o = 1'b0;
    emit_fire  = 1'b0;
    issue      = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_EMIT:  emit_fire  = slot_free;
      ST_PASS:  issue      = 1'b1;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= CNT_W'(MAX_NODES);
      cnt_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      init_q      <= 1'b0;
      root_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= issue;
      if (start) begin
        n_q    <= clamp_count(node_count_i);
        cnt_q  <= '0;
        root_q <= 1'b1;
      end
      if (emit_fire) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        root_q <= 1'b0;
        init_q <= root_q;
        k_q    <= emit_k;
        j_q    <= NODE_W'(1);
      end
      if (issue) begin
        j_q <= j_q + NODE_W'(1);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_j_q <= j_q;
    if (emit_fire) begin
      vertex_q <= VTX_W'(emit_k);
      parent_q <= VTX_W'(emit_p);
      last_q   <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign parent_o    = parent_q;
  assign last_o      = last_q;

  assign rd_j_o = j_q;
  assign rd_k_o = k_q;

  // the joining vertex is flagged in the vertex table
  assign mark_we_o   = emit_fire;
  assign mark_addr_o = emit_k;

  always_comb begin
    req_o       = '0;
    req_o.valid = s1_v_q;
    req_o.init  = init_q;
    req_o.clear = emit_fire && !emit_last;
    req_o.j     = s1_j_q;
    req_o.k     = k_q;
  end

  a_s1_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> $past(state_q == ST_PASS))
    else $error("relax stage active without a preceding read");

  a_emit_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && !root_q) |-> (res_i.k != '0))
    else $error("root vertex emitted twice in one run");

  a_mark_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !s1_v_q)
    else $error("vertex table written twice in one cycle");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !root_q) |-> res_i.found)
    else $error("emit without a candidate vertex");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q < n_q))
    else $error("emit count beyond vertex count");

endmodule

### sv/prim_spanning_tree.sv
// load request: no result. start request: vertex 0 leaves first, each further vertex
// after a pass of one vertex-table read per vertex other than vertex 0, up to the last
// of the n vertices in use.
// input is accepted only between runs; output stalls hold the engine in place.
// reset clears control and sets node_count to 64; the distance matrix and vertex
// table are not cleared, the first pass of each run rewrites the vertex table.
module prim_spanning_tree
  import spt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [VTX_W-1:0]     row_index_i,
  input  logic [VTX_W-1:0]     col_index_i,
  input  logic [IN_DIST_W-1:0] distance_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [VTX_W-1:0]     vertex_o,
  output logic [VTX_W-1:0]     parent_o,
  output logic                 last_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [NCNT_W-1:0]     node_count_q;
  logic                  load_we;
  logic [DADR_W-1:0]     load_addr;
  logic [DIST_WIDTH-1:0] dist_rdata;
  logic [NODE_W-1:0]     rd_j, rd_k;
  relax_req_t            req;
  relax_res_t            res;
  logic                  relax_we;
  vtx_entry_t            relax_wdata;
  logic                  mark_we;
  logic [NODE_W-1:0]     mark_addr;
  vtx_entry_t            mark_wdata;
  logic                  vtx_we;
  logic [NODE_W-1:0]     vtx_waddr;
  vtx_entry_t            vtx_wdata;
  vtx_entry_t            vtx_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCNT_W'(MAX_NODES);
    end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[NCNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : '0;

  // entries outside the matrix are dropped
  assign load_we = in_valid_i && in_ready_o && (operation_i == OP_LOAD) &&
                   (NCNT_W'(row_index_i) < NCNT_W'(MAX_NODES)) &&
                   (NCNT_W'(col_index_i) < NCNT_W'(MAX_NODES));
  assign load_addr = {row_index_i[NODE_W-1:0], col_index_i[NODE_W-1:0]};

  spt_ram #(
    .WIDTH(DIST_WIDTH),
    .DEPTH(1 << DADR_W)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(load_addr),
    .wdata_i(sat_dist(distance_i)),
    .raddr_i({rd_k, rd_j}),
    .rdata_o(dist_rdata)
  );

  // marking happens only in the emit cycle, when the relax stage is idle
  assign mark_wdata = '{cost: INFINITE, parent: '0, in_tree: 1'b1};
  assign vtx_we     = relax_we || mark_we;
  assign vtx_waddr  = mark_we ? mark_addr : req.j;
  assign vtx_wdata  = mark_we ? mark_wdata : relax_wdata;

  spt_ram #(
    .WIDTH($bits(vtx_entry_t)),
    .DEPTH(1 << NODE_W)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (vtx_we),
    .waddr_i(vtx_waddr),
    .wdata_i(vtx_wdata),
    .raddr_i(rd_j),
    .rdata_o(vtx_rdata)
  );

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .node_count_i(node_count_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vertex_o    (vertex_o),
    .parent_o    (parent_o),
    .last_o      (last_o),
    .rd_j_o      (rd_j),
    .rd_k_o      (rd_k),
    .mark_we_o   (mark_we),
    .mark_addr_o (mark_addr),
    .req_o       (req),
    .res_i       (res)
  );

  spt_relax u_relax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .dist_i (dist_rdata),
    .entry_i(vtx_rdata),
    .we_o   (relax_we),
    .wdata_o(relax_wdata),
    .res_o  (res)
  );

endmodule
